[hw/rtl/u8rs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8rs_pkg
// Shared types, codes and constants of the UTF-8 replacement sanitizer.
// ----------------------------------------------------------------------------
package u8rs_pkg;

   // request codes
   localparam logic REQ_DATA  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // replacement character U+FFFD
   localparam logic [7:0] REP_BYTE0 = 8'hEF;
   localparam logic [7:0] REP_BYTE1 = 8'hBF;
   localparam logic [7:0] REP_BYTE2 = 8'hBD;

   // lead and continuation ranges
   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] LEAD2_LO     = 8'hC2;
   localparam logic [7:0] LEAD2_HI     = 8'hDF;
   localparam logic [7:0] LEAD3_LO     = 8'hE0;
   localparam logic [7:0] LEAD3_HI     = 8'hEF;
   localparam logic [7:0] LEAD4_LO     = 8'hF0;
   localparam logic [7:0] LEAD4_HI     = 8'hF4;
   localparam logic [7:0] LEAD_E0      = 8'hE0;
   localparam logic [7:0] LEAD_ED      = 8'hED;
   localparam logic [7:0] LEAD_F0      = 8'hF0;
   localparam logic [7:0] LEAD_F4      = 8'hF4;
   localparam logic [7:0] CONT_A0      = 8'hA0;
   localparam logic [7:0] CONT_90      = 8'h90;
   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_TAG     = 8'h80;

   // default depth of the command queue
   localparam int QUEUE_DEPTH_DEF = 2;

   // input word
   typedef struct packed {
      logic       req_type;
      logic [7:0] in_byte;
   } req_word_type;

   // output word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_replacement;
      logic       last;
   } rsp_word_type;

   // emission command: optional replacement, literal bytes, optional replacement
   typedef struct packed {
      logic            rep_first;
      logic [2:0]      lit_count;
      logic [3:0][7:0] lit;
      logic            rep_last;
   } cmd_type;

   // byte of the replacement sequence by position
   function automatic logic [7:0] rep_byte(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = REP_BYTE0;
         2'd1:    r = REP_BYTE1;
         default: r = REP_BYTE2;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/u8rs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8rs_front
// Accepts input words, tracks the held partial sequence and turns each word
// into at most one emission command for the queue.
// ----------------------------------------------------------------------------
module u8rs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  u8rs_pkg::req_word_type req_word,
   input  logic                  queue_full,
   output logic                  push,
   output u8rs_pkg::cmd_type     push_cmd
);
   import u8rs_pkg::*;

   logic [1:0] count_ff, count_in;
   logic [2:0] exp_len_ff, exp_len_in;
   logic [7:0] pend_ff [3];
   logic       accept;
   logic       has_result;
   logic       wr_en;
   logic [1:0] wr_idx;
   logic [7:0] b;
   logic [2:0] lead_len;
   logic       is_ascii;
   logic       cont_ok;

   // length that a lead byte announces, zero when not a lead
   function automatic logic [2:0] get_lead_len(input logic [7:0] v);
      logic [2:0] l;
      if (v >= LEAD2_LO && v <= LEAD2_HI) l = 3'd2;
      else if (v >= LEAD3_LO && v <= LEAD3_HI) l = 3'd3;
      else if (v >= LEAD4_LO && v <= LEAD4_HI) l = 3'd4;
      else l = 3'd0;
      return l;
   endfunction

   assign b         = req_word.in_byte;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept && has_result;
   assign is_ascii  = (b < ASCII_LIMIT);
   assign lead_len  = get_lead_len(b);

   // does the byte continue the held sequence
   always_comb begin
      cont_ok = ((b & CONT_MASK) == CONT_TAG);
      if (count_ff == 2'd1) begin
         if (pend_ff[0] == LEAD_E0 && b <  CONT_A0) cont_ok = 1'b0;
         if (pend_ff[0] == LEAD_ED && b >= CONT_A0) cont_ok = 1'b0;
         if (pend_ff[0] == LEAD_F0 && b <  CONT_90) cont_ok = 1'b0;
         if (pend_ff[0] == LEAD_F4 && b >= CONT_90) cont_ok = 1'b0;
      end
   end

   // classify the word and build its command
   always_comb begin
      count_in   = count_ff;
      exp_len_in = exp_len_ff;
      has_result = 1'b0;
      push_cmd   = '0;
      wr_en      = 1'b0;
      wr_idx     = count_ff;
      if (req_word.req_type == REQ_FLUSH) begin
         if (count_ff != 2'd0) begin
            has_result         = 1'b1;
            push_cmd.rep_first = 1'b1;
         end
         count_in   = 2'd0;
         exp_len_in = 3'd0;
      end else if (count_ff != 2'd0 && cont_ok) begin
         if ({1'b0, count_ff} + 3'd1 == exp_len_ff) begin
            // sequence complete: release held bytes and this one
            has_result         = 1'b1;
            push_cmd.lit_count = {1'b0, count_ff} + 3'd1;
            push_cmd.lit[0]    = pend_ff[0];
            push_cmd.lit[1]    = (count_ff == 2'd1) ? b : pend_ff[1];
            push_cmd.lit[2]    = (count_ff == 2'd2) ? b : pend_ff[2];
            push_cmd.lit[3]    = b;
            count_in           = 2'd0;
            exp_len_in         = 3'd0;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + 2'd1;
         end
      end else begin
         // broken hold gives one replacement, then the byte is taken fresh
         if (count_ff != 2'd0) begin
            has_result         = 1'b1;
            push_cmd.rep_first = 1'b1;
         end
         count_in   = 2'd0;
         exp_len_in = 3'd0;
         if (is_ascii) begin
            has_result         = 1'b1;
            push_cmd.lit_count = 3'd1;
            push_cmd.lit[0]    = b;
         end else if (lead_len != 3'd0) begin
            wr_en      = 1'b1;
            wr_idx     = 2'd0;
            count_in   = 2'd1;
            exp_len_in = lead_len;
         end else begin
            has_result = 1'b1;
            if (count_ff != 2'd0) push_cmd.rep_last = 1'b1;
            else push_cmd.rep_first = 1'b1;
         end
      end
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 2'd0;
         exp_len_ff <= 3'd0;
      end else if (accept) begin
         count_ff   <= count_in;
         exp_len_ff <= exp_len_in;
      end
   end

   // held bytes
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         pend_ff[wr_idx] <= b;
      end
   end

endmodule

[hw/rtl/u8rs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8rs_queue
// Short command queue that decouples the classifier from the emitter.
// ----------------------------------------------------------------------------
module u8rs_queue #(
   parameter int DEPTH = u8rs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u8rs_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output u8rs_pkg::cmd_type head
);
   import u8rs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hw/rtl/u8rs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8rs_back
// Expands the command at the queue head into output words, one per cycle
// while rsp_stall allows it, through a registered output stage.
// ----------------------------------------------------------------------------
module u8rs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  u8rs_pkg::cmd_type     head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output u8rs_pkg::rsp_word_type rsp_word
);
   import u8rs_pkg::*;

   logic [2:0]   pos_ff, pos_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         advance;
   logic [2:0]   rep1_len;
   logic [2:0]   lit_end;
   logic [3:0]   total;
   logic [2:0]   lit_off;
   logic [2:0]   rep2_off;
   logic         is_last;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign rep1_len  = head.rep_first ? 3'd3 : 3'd0;
   assign lit_end   = rep1_len + head.lit_count;
   assign total     = {1'b0, lit_end} + (head.rep_last ? 4'd3 : 4'd0);
   assign lit_off   = pos_ff - rep1_len;
   assign rep2_off  = pos_ff - lit_end;
   assign is_last   = ({1'b0, pos_ff} + 4'd1 == total);
   assign pop       = head_valid && advance && is_last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // pick the byte at the current position of the command
   always_comb begin
      rsp_word_in.last = is_last;
      if (pos_ff < rep1_len) begin
         rsp_word_in.out_byte       = rep_byte(pos_ff[1:0]);
         rsp_word_in.is_replacement = 1'b1;
      end else if (pos_ff < lit_end) begin
         rsp_word_in.out_byte       = head.lit[lit_off[1:0]];
         rsp_word_in.is_replacement = 1'b0;
      end else begin
         rsp_word_in.out_byte       = rep_byte(rep2_off[1:0]);
         rsp_word_in.is_replacement = 1'b1;
      end
   end

   // position and output valid
   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = head_valid;
         if (head_valid) pos_in = is_last ? 3'd0 : pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (advance && head_valid) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

[hw/rtl/utf8_replacement_sanitizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_replacement_sanitizer_core
// UTF-8 sanitizer: well-formed sequences pass, each maximal ill-formed
// subpart becomes EF BF BD.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per accepted item, a data byte or a final flush
//   (req_type). Accepted when req_valid is high and req_stall low.
//   rsp channel: one output byte per word, tagged is_replacement, with last
//   set on the final byte caused by an item. A partial sequence is held in
//   the front until it completes, breaks, or a flush arrives.
// Path: an accepted item goes into the command queue, and its first byte
//   reaches rsp from the output word register. Held bytes produce nothing.
// Throughput: one output byte per cycle while rsp_stall is low, set by the
//   emitter; an item that gives k bytes (k up to 6) keeps the emitter until
//   its last byte goes, and plain ASCII moves at one byte per cycle.
// The front and emitter are parted by a command queue of QUEUE_DEPTH
//   entries; req_stall rises only when that queue is full.
// Reset: clears the held sequence, the queue and the output valid.
// Receiver stall: the output word holds, the emitter waits, the queue fills
//   and then the input is stalled.
// ----------------------------------------------------------------------------
module utf8_replacement_sanitizer_core #(
   parameter int QUEUE_DEPTH = u8rs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  u8rs_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output u8rs_pkg::rsp_word_type rsp_word
);
   import u8rs_pkg::*;

   logic    queue_full;
   logic    queue_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type head;

   // classifier front
   u8rs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // command queue
   u8rs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head)
   );

   // emitter back
   u8rs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!queue_empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

[hw/rtl/u8rs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8rs_checker
// Port-level checks on the sanitizer output stream.
// ----------------------------------------------------------------------------
module u8rs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input u8rs_pkg::rsp_word_type rsp_word
);
   import u8rs_pkg::*;

   logic rsp_fire;
   assign rsp_fire = rsp_valid && !rsp_stall;

   // output is empty right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled output word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   // inserted bytes are only EF BF BD
   a_rep_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_word.is_replacement |->
         (rsp_word.out_byte == REP_BYTE0 || rsp_word.out_byte == REP_BYTE1 ||
          rsp_word.out_byte == REP_BYTE2))
      else $error("bad replacement byte");

   // an item ending in a replacement ends on its final byte
   a_rep_last: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_word.is_replacement && rsp_word.last |->
         rsp_word.out_byte == REP_BYTE2)
      else $error("replacement cut short");

   // a passed-through final byte is ASCII or a continuation byte
   a_plain_last: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_word.is_replacement && rsp_word.last |->
         (rsp_word.out_byte < ASCII_LIMIT ||
          (rsp_word.out_byte & CONT_MASK) == CONT_TAG))
      else $error("passed sequence ends on a lead byte");

endmodule

bind utf8_replacement_sanitizer_core u8rs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the UTF-8 replacement sanitizer: a short table of
// directed bytes and flushes, then mostly well-formed random characters with
// truncated, corrupted and flushed sequences mixed in. Every result word is
// compared with a typed-in expectation or a cycle-free model of the decoder,
// with random idling on both channels and two full drains of the output.
// ----------------------------------------------------------------------------
module tb;
   import u8rs_pkg::*;

   localparam int CLK_HALF   = 4;
   localparam int RAND_ITEMS = 404;
   localparam int CYCLE_CAP  = 500000;
   localparam int TAIL_WAIT  = 16;
   localparam logic [23:0] FFFD = {REP_BYTE0, REP_BYTE1, REP_BYTE2};

   // one row of stimulus, with an optional typed-in expectation
   typedef struct packed {
      req_word_type word;
      logic         typed;
      logic         drain;
      logic [2:0]   n_typed;
      logic [47:0]  typed_bytes;
      logic [5:0]   typed_rep;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   stim_row_type stim_rows[$];
   stim_row_type cur_row;
   rsp_word_type expected_words[$];
   rsp_word_type step_words[$];

   // decoder state of the model
   logic [7:0] held_bytes[3];
   logic [1:0] held_count;
   logic [2:0] want_len;

   int  error_count;
   int  words_in;
   int  flushes_in;
   int  words_out;
   int  rep_words_out;
   int  cycle_count;
   logic calm;

   utf8_replacement_sanitizer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------
   // decoder model
   // ---------------------------------------------------------------------
   function automatic void emit_byte(logic [7:0] b, logic rep);
      rsp_word_type w;
      w.out_byte       = b;
      w.is_replacement = rep;
      w.last           = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void emit_fffd();
      emit_byte(REP_BYTE0, 1'b1);
      emit_byte(REP_BYTE1, 1'b1);
      emit_byte(REP_BYTE2, 1'b1);
   endfunction

   // byte seen with nothing held: pass, open a sequence or replace
   function automatic void take_fresh(logic [7:0] b);
      if (b < ASCII_LIMIT) begin
         emit_byte(b, 1'b0);
      end else if (b >= LEAD2_LO && b <= LEAD4_HI) begin
         held_bytes[0] = b;
         held_count    = 2'd1;
         if (b <= LEAD2_HI)
            want_len = 3'd2;
         else if (b <= LEAD3_HI)
            want_len = 3'd3;
         else
            want_len = 3'd4;
      end else begin
         emit_fffd();
      end
   endfunction

   // continuation check, with the narrowed second byte after some leads
   function automatic logic extends_held(logic [7:0] b);
      logic ok;
      ok = ((b & CONT_MASK) == CONT_TAG);
      if (held_count == 2'd1) begin
         if (held_bytes[0] == LEAD_E0 && b < CONT_A0) ok = 1'b0;
         if (held_bytes[0] == LEAD_ED && b >= CONT_A0) ok = 1'b0;
         if (held_bytes[0] == LEAD_F0 && b < CONT_90) ok = 1'b0;
         if (held_bytes[0] == LEAD_F4 && b >= CONT_90) ok = 1'b0;
      end
      return ok;
   endfunction

   // output words caused by one accepted input word, left in step_words
   function automatic void sanitize_word(req_word_type w);
      int i;
      step_words.delete();
      if (w.req_type == REQ_FLUSH) begin
         if (held_count != 2'd0) begin
            emit_fffd();
            held_count = 2'd0;
            want_len   = 3'd0;
         end
      end else if (held_count == 2'd0) begin
         take_fresh(w.in_byte);
      end else if (extends_held(w.in_byte)) begin
         if (held_count + 3'd1 == want_len) begin
            for (i = 0; i < held_count; i++)
               emit_byte(held_bytes[i], 1'b0);
            emit_byte(w.in_byte, 1'b0);
            held_count = 2'd0;
            want_len   = 3'd0;
         end else begin
            held_bytes[held_count] = w.in_byte;
            held_count = held_count + 2'd1;
         end
      end else begin
         // breaking byte: replace the held part, then start over with it
         emit_fffd();
         held_count = 2'd0;
         want_len   = 3'd0;
         take_fresh(w.in_byte);
      end
      if (step_words.size() > 0)
         step_words[step_words.size() - 1].last = 1'b1;
   endfunction

   function automatic stim_row_type make_row(logic t, logic [7:0] b, logic typed,
                                             logic [2:0] n, logic [47:0] bytes,
                                             logic [5:0] rep);
      stim_row_type r;
      r.word.req_type = t;
      r.word.in_byte  = b;
      r.typed         = typed;
      r.drain         = 1'b0;
      r.n_typed       = n;
      r.typed_bytes   = bytes;
      r.typed_rep     = rep;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // cycle limit
   // ---------------------------------------------------------------------
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_words.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // prediction at input acceptance, checking at output acceptance
   // ---------------------------------------------------------------------
   initial begin
      error_count   = 0;
      words_in      = 0;
      flushes_in    = 0;
      words_out     = 0;
      rep_words_out = 0;
      held_bytes[0] = 8'h00;
      held_bytes[1] = 8'h00;
      held_bytes[2] = 8'h00;
      held_count    = 2'd0;
      want_len      = 3'd0;
   end

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type typed_w;
      int i;
      if (!reset) begin
         // input word accepted
         if (req_valid && !req_stall) begin
            sanitize_word(cur_row.word);
            words_in++;
            if (cur_row.word.req_type == REQ_FLUSH) flushes_in++;
            if (cur_row.typed) begin
               for (i = 0; i < cur_row.n_typed; i++) begin
                  typed_w.out_byte       = cur_row.typed_bytes[47 - 8 * i -: 8];
                  typed_w.is_replacement = cur_row.typed_rep[5 - i];
                  typed_w.last           = (i == cur_row.n_typed - 1);
                  expected_words.push_back(typed_w);
               end
            end else begin
               foreach (step_words[i])
                  expected_words.push_back(step_words[i]);
            end
         end
         // output word accepted
         if (rsp_valid && !rsp_stall) begin
            words_out++;
            if (rsp_word.is_replacement) rep_words_out++;
            if (expected_words.size() == 0) begin
               error_count++;
               $display("%0t unexpected word: expected none, actual byte %02h rep %0d last %0d",
                        $time, rsp_word.out_byte, rsp_word.is_replacement, rsp_word.last);
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.out_byte !== want.out_byte) begin
                  error_count++;
                  $display("%0t out_byte mismatch: expected %02h actual %02h",
                           $time, want.out_byte, rsp_word.out_byte);
               end
               if (rsp_word.is_replacement !== want.is_replacement) begin
                  error_count++;
                  $display("%0t is_replacement mismatch on %02h: expected %0d actual %0d",
                           $time, want.out_byte, want.is_replacement,
                           rsp_word.is_replacement);
               end
               if (rsp_word.last !== want.last) begin
                  error_count++;
                  $display("%0t last mismatch on %02h: expected %0d actual %0d",
                           $time, want.out_byte, want.last, rsp_word.last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // output side: random stall ahead of every word
   // ---------------------------------------------------------------------
   initial begin
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 19);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type row;
      logic [7:0] seq[4];
      logic [7:0] lo;
      logic [7:0] hi;
      int pick;
      int len;
      int keep;
      int mangle;
      int rand_rows;
      int gap;
      int idx;
      int i;

      calm      = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      cur_row   <= '0;

      // directed table: extremes, stray bytes, narrowed second bytes, flushes
      stim_rows.push_back(make_row(REQ_DATA, 8'h00, 1'b1, 3'd1, {8'h00, 40'h0}, 6'b000000));
      stim_rows.push_back(make_row(REQ_DATA, 8'h7F, 1'b1, 3'd1, {8'h7F, 40'h0}, 6'b000000));
      stim_rows.push_back(make_row(REQ_DATA, 8'h80, 1'b1, 3'd3, {FFFD, 24'h0}, 6'b111000));
      stim_rows.push_back(make_row(REQ_DATA, 8'hFF, 1'b1, 3'd3, {FFFD, 24'h0}, 6'b111000));
      stim_rows.push_back(make_row(REQ_FLUSH, 8'hFF, 1'b1, 3'd0, 48'h0, 6'b000000));
      stim_rows.push_back(make_row(REQ_DATA, 8'hC2, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'h80, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'hE0, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'hA0, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'h80, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'hE0, 1'b1, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'h9F, 1'b1, 3'd6, {FFFD, FFFD}, 6'b111111));
      stim_rows.push_back(make_row(REQ_DATA, 8'hED, 1'b1, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'hA0, 1'b1, 3'd6, {FFFD, FFFD}, 6'b111111));
      stim_rows.push_back(make_row(REQ_DATA, 8'hF0, 1'b1, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'h8F, 1'b1, 3'd6, {FFFD, FFFD}, 6'b111111));
      stim_rows.push_back(make_row(REQ_DATA, 8'hF4, 1'b1, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'h90, 1'b1, 3'd6, {FFFD, FFFD}, 6'b111111));
      stim_rows.push_back(make_row(REQ_DATA, 8'hE2, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'h41, 1'b1, 3'd4, {FFFD, 8'h41, 16'h0},
                                   6'b111000));
      stim_rows.push_back(make_row(REQ_DATA, 8'hF0, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'h90, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'h80, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'h80, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_DATA, 8'hE1, 1'b0, 3'd0, 48'h0, 6'b0));
      stim_rows.push_back(make_row(REQ_FLUSH, 8'h00, 1'b1, 3'd3, {FFFD, 24'h0}, 6'b111000));

      // drain the output once after the table
      row = stim_rows[stim_rows.size() - 1];
      row.drain = 1'b1;
      stim_rows[stim_rows.size() - 1] = row;

      // random part: mostly well-formed characters, some broken, some noise
      rand_rows = 0;
      while (rand_rows < RAND_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            stim_rows.push_back(make_row(REQ_FLUSH, 8'($urandom_range(0, 255)), 1'b0,
                                         3'd0, 48'h0, 6'b0));
            rand_rows++;
         end else if (pick < 20) begin
            stim_rows.push_back(make_row(REQ_DATA, 8'($urandom_range(0, 255)), 1'b0,
                                         3'd0, 48'h0, 6'b0));
            rand_rows++;
         end else begin
            len = $urandom_range(1, 4);
            seq[1] = 8'($urandom_range(8'h80, 8'hBF));
            seq[2] = 8'($urandom_range(8'h80, 8'hBF));
            seq[3] = 8'($urandom_range(8'h80, 8'hBF));
            lo = 8'h80;
            hi = 8'hBF;
            case (len)
               1: seq[0] = 8'($urandom_range(0, 8'h7F));
               2: seq[0] = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
               3: begin
                  seq[0] = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
                  if (seq[0] == LEAD_E0) lo = CONT_A0;
                  if (seq[0] == LEAD_ED) hi = 8'h9F;
               end
               default: begin
                  seq[0] = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
                  if (seq[0] == LEAD_F0) lo = CONT_90;
                  if (seq[0] == LEAD_F4) hi = 8'h8F;
               end
            endcase
            if (len > 1) seq[1] = 8'($urandom_range(lo, hi));
            keep   = len;
            mangle = -1;
            if (len > 1 && $urandom_range(0, 99) < 22) begin
               mangle = $urandom_range(0, 2);
               if (mangle == 1)
                  seq[2'($urandom_range(1, len - 1))] = 8'($urandom_range(0, 255));
               else
                  keep = $urandom_range(1, len - 1);
            end
            for (i = 0; i < keep; i++) begin
               stim_rows.push_back(make_row(REQ_DATA, seq[i], 1'b0, 3'd0, 48'h0, 6'b0));
               rand_rows++;
            end
            // truncated sequence closed by the end of input
            if (mangle == 2) begin
               stim_rows.push_back(make_row(REQ_FLUSH, 8'h00, 1'b0, 3'd0, 48'h0, 6'b0));
               rand_rows++;
            end
         end
      end

      // second full drain halfway through the random part
      idx = stim_rows.size() - RAND_ITEMS / 2;
      row = stim_rows[idx];
      row.drain = 1'b1;
      stim_rows[idx] = row;

      // a lead byte left held at the end, never flushed
      stim_rows.push_back(make_row(REQ_DATA, 8'hE1, 1'b0, 3'd0, 48'h0, 6'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // drive every word, holding it until accepted
      for (idx = 0; idx < stim_rows.size(); idx++) begin
         row  = stim_rows[idx];
         calm = ((idx / 50) % 5) == 4;
         gap  = calm ? 0 : $urandom_range(0, 19);
         if (gap > 0 || row.drain) begin
            req_valid <= 1'b0;
            repeat (gap > 0 ? gap : 1) @(posedge clock);
            if (row.drain)
               while (expected_words.size() != 0) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_word  <= row.word;
         cur_row   <= row;
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      $display("sent %0d input words (%0d flushes): table of edge cases plus random text",
               words_in, flushes_in);
      $display("checked %0d output words, %0d of them replacement bytes, %0d errors",
               words_out, rep_words_out, error_count);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d words still expected at the end", expected_words.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/u8rs_pkg.sv
hw/rtl/u8rs_front.sv
hw/rtl/u8rs_queue.sv
hw/rtl/u8rs_back.sv
hw/rtl/utf8_replacement_sanitizer_core.sv
hw/rtl/u8rs_checker.sv
tb/sv/tb.sv
